@@ sv/ctk_pkg.sv @@
`default_nettype none

package ctk_pkg;

   localparam int DIV_WIDTH   = 31;
   localparam int REM_WIDTH   = 9;
   localparam int MAGIC_WIDTH = 32;
   localparam int SCALE_WIDTH = 6;
   localparam int PROD_WIDTH  = DIV_WIDTH + MAGIC_WIDTH;

   // op codes
   localparam logic [2:0] OP_ADVANCE   = 3'd0;
   localparam logic [2:0] OP_SET_HOUR  = 3'd1;
   localparam logic [2:0] OP_SET_DAY   = 3'd2;
   localparam logic [2:0] OP_SET_MONTH = 3'd3;
   localparam logic [2:0] OP_SET_YEAR  = 3'd4;
   localparam logic [2:0] OP_SET_DAYS  = 3'd5;

   // one day is 24 << 16 = 3 << 19, so the hour split divides t >> 19 by 3
   localparam int          HOUR_SHIFT    = 19;
   localparam logic [8:0]  HOUR_DIVISOR  = 9'd3;
   localparam logic [8:0]  YEAR_DIVISOR  = 9'd365;
   localparam logic [8:0]  MONTH_DIVISOR = 9'd12;
   localparam logic [20:0] HOUR_LIMIT    = 21'd1572864;
   localparam logic [3:0]  LAST_MONTH    = 4'd11;

   // x / d == (x * magic) >> scale exactly for any 31-bit x
   localparam logic [MAGIC_WIDTH-1:0] HOUR_MAGIC  = 32'hAAAA_AAAB;
   localparam logic [SCALE_WIDTH-1:0] HOUR_SCALE  = 6'd33;
   localparam logic [MAGIC_WIDTH-1:0] MONTH_MAGIC = 32'hAAAA_AAAB;
   localparam logic [SCALE_WIDTH-1:0] MONTH_SCALE = 6'd35;
   localparam logic [MAGIC_WIDTH-1:0] YEAR_MAGIC  = 32'd3012360625;
   localparam logic [SCALE_WIDTH-1:0] YEAR_SCALE  = 6'd40;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_HOUR,
      ST_DIV_DAY,
      ST_DIV_MONTH,
      ST_WALK,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic                   start;
      logic [DIV_WIDTH-1:0]   dividend;
      logic [REM_WIDTH-1:0]   divisor;
      logic [MAGIC_WIDTH-1:0] magic;
      logic [SCALE_WIDTH-1:0] scale;
   } div_req_type;

   typedef struct packed {
      logic                   done;
      logic [DIV_WIDTH-1:0]   quotient;
      logic [REM_WIDTH-1:0]   remainder;
   } div_rsp_type;

   function automatic logic [4:0] month_len(logic [3:0] m);
      logic [4:0] len;
      unique case (m)
         4'd1:                      len = 5'd28;
         4'd3, 4'd5, 4'd8, 4'd10:   len = 5'd30;
         default:                   len = 5'd31;
      endcase
      return len;
   endfunction

endpackage

`default_nettype wire

@@ sv/calendar_time_keeper_unit.sv @@
`default_nettype none

// Channel   Dir  Handshake              Payload
// req_      in   req_valid / req_stall  req_op, req_hours_value, req_int_value
// rsp_      out  rsp_valid / rsp_stall  hour, day, month, year, days elapsed, flag
//
// One transaction at a time; req_stall is high until the sequencer is idle again.
// Every divide goes through one shared reciprocal multiplier.
// Per op: advance / set hour divide, plus a year divide and up to 11 month steps on
// a day carry; set day divide plus month steps; set month divide; year/days none.
// Synchronous reset: hour 0, day 1, month 0, year 0, days passed 0.
// A new transaction may start while the last result is stalled on rsp_.
module calendar_time_keeper_unit (
   input  wire                clock,
   input  wire                reset,
   input  wire                req_valid,
   output logic               req_stall,
   input  wire  [2:0]         req_op,
   input  wire  signed [47:0] req_hours_value,
   input  wire  signed [31:0] req_int_value,
   output logic               rsp_valid,
   input  wire                rsp_stall,
   output logic [20:0]        rsp_hour_of_day,
   output logic [4:0]         rsp_day_of_month,
   output logic [3:0]         rsp_month_index,
   output logic signed [31:0] rsp_year_count,
   output logic signed [31:0] rsp_days_elapsed,
   output logic               rsp_date_changed
);

   ctk_pkg::state_type    state_ff, state_in;
   ctk_pkg::div_req_type  div_req;
   ctk_pkg::div_rsp_type  div_rsp;

   logic [2:0]   op_ff, op_in;
   logic [20:0]  hour_ff, hour_in;
   logic [4:0]   day_ff, day_in;
   logic [3:0]   month_ff, month_in;
   logic [31:0]  year_ff, year_in;
   logic [31:0]  days_ff, days_in;
   logic [8:0]   walk_day_ff, walk_day_in;
   logic [18:0]  t_lo_ff, t_lo_in;

   logic         rsp_valid_ff, rsp_valid_in;
   logic [20:0]  rsp_hour_ff;
   logic [4:0]   rsp_day_ff;
   logic [3:0]   rsp_month_ff;
   logic [31:0]  rsp_year_ff;
   logic [31:0]  rsp_days_ff;
   logic         rsp_flag_ff;
   logic         rsp_load;

   logic [48:0]  t_sum;
   logic [47:0]  t_clamp;
   logic [4:0]   walk_len;
   logic [4:0]   new_len;
   logic         flag;

   ctk_divider u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_rsp (div_rsp)
   );

   assign t_sum   = {req_hours_value[47], req_hours_value}
                  + ((req_op == ctk_pkg::OP_ADVANCE) ? {28'd0, hour_ff} : 49'd0);
   assign t_clamp = t_sum[48] ? 48'd0 : t_sum[47:0];
   assign walk_len = ctk_pkg::month_len(month_ff);
   assign new_len  = ctk_pkg::month_len(div_rsp.remainder[3:0]);
   assign flag     = (op_ff == ctk_pkg::OP_SET_HOUR) || (op_ff == ctk_pkg::OP_SET_DAY)
                  || (op_ff == ctk_pkg::OP_SET_MONTH);

   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      hour_in      = hour_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      days_in      = days_ff;
      walk_day_in  = walk_day_ff;
      t_lo_in      = t_lo_ff;
      div_req      = '0;
      rsp_load     = 1'b0;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      req_stall    = (state_ff != ctk_pkg::ST_IDLE);

      unique case (state_ff)
         ctk_pkg::ST_IDLE: begin
            if (req_valid) begin
               op_in   = req_op;
               t_lo_in = t_clamp[ctk_pkg::HOUR_SHIFT-1:0];
               unique case (req_op)
                  ctk_pkg::OP_ADVANCE, ctk_pkg::OP_SET_HOUR: begin
                     div_req.start    = 1'b1;
                     div_req.dividend = {2'b00, t_clamp[47:ctk_pkg::HOUR_SHIFT]};
                     div_req.divisor  = ctk_pkg::HOUR_DIVISOR;
                     div_req.magic    = ctk_pkg::HOUR_MAGIC;
                     div_req.scale    = ctk_pkg::HOUR_SCALE;
                     state_in         = ctk_pkg::ST_DIV_HOUR;
                  end
                  ctk_pkg::OP_SET_DAY: begin
                     // clamp to day 1, then divide day - 1 by the year length
                     div_req.start    = 1'b1;
                     div_req.dividend = (req_int_value[31] || req_int_value == 32'sd0)
                                      ? 31'd0 : req_int_value[30:0] - 31'd1;
                     div_req.divisor  = ctk_pkg::YEAR_DIVISOR;
                     div_req.magic    = ctk_pkg::YEAR_MAGIC;
                     div_req.scale    = ctk_pkg::YEAR_SCALE;
                     state_in         = ctk_pkg::ST_DIV_DAY;
                  end
                  ctk_pkg::OP_SET_MONTH: begin
                     div_req.start    = 1'b1;
                     div_req.dividend = req_int_value[31] ? 31'd0 : req_int_value[30:0];
                     div_req.divisor  = ctk_pkg::MONTH_DIVISOR;
                     div_req.magic    = ctk_pkg::MONTH_MAGIC;
                     div_req.scale    = ctk_pkg::MONTH_SCALE;
                     state_in         = ctk_pkg::ST_DIV_MONTH;
                  end
                  ctk_pkg::OP_SET_YEAR: begin
                     year_in  = req_int_value;
                     state_in = ctk_pkg::ST_FINISH;
                  end
                  ctk_pkg::OP_SET_DAYS: begin
                     days_in  = req_int_value;
                     state_in = ctk_pkg::ST_FINISH;
                  end
                  default: begin
                     state_in = ctk_pkg::ST_FINISH;
                  end
               endcase
            end
         end
         ctk_pkg::ST_DIV_HOUR: begin
            if (div_rsp.done) begin
               hour_in = {div_rsp.remainder[1:0], t_lo_ff};
               if (div_rsp.quotient == '0) begin
                  state_in = ctk_pkg::ST_FINISH;
               end else begin
                  if (op_ff == ctk_pkg::OP_ADVANCE) begin
                     days_in = days_ff + {1'b0, div_rsp.quotient};
                  end
                  div_req.start    = 1'b1;
                  div_req.dividend = div_rsp.quotient + {26'd0, day_ff} - 31'd1;
                  div_req.divisor  = ctk_pkg::YEAR_DIVISOR;
                  div_req.magic    = ctk_pkg::YEAR_MAGIC;
                  div_req.scale    = ctk_pkg::YEAR_SCALE;
                  state_in         = ctk_pkg::ST_DIV_DAY;
               end
            end
         end
         ctk_pkg::ST_DIV_DAY: begin
            if (div_rsp.done) begin
               year_in     = year_ff + {1'b0, div_rsp.quotient};
               walk_day_in = div_rsp.remainder + 9'd1;
               state_in    = ctk_pkg::ST_WALK;
            end
         end
         ctk_pkg::ST_WALK: begin
            // one month per cycle, at most a year's worth
            if (walk_day_ff > {4'd0, walk_len}) begin
               walk_day_in = walk_day_ff - {4'd0, walk_len};
               if (month_ff == ctk_pkg::LAST_MONTH) begin
                  month_in = 4'd0;
                  year_in  = year_ff + 32'd1;
               end else begin
                  month_in = month_ff + 4'd1;
               end
            end else begin
               day_in   = walk_day_ff[4:0];
               state_in = ctk_pkg::ST_FINISH;
            end
         end
         ctk_pkg::ST_DIV_MONTH: begin
            if (div_rsp.done) begin
               year_in  = year_ff + {1'b0, div_rsp.quotient};
               month_in = div_rsp.remainder[3:0];
               if (day_ff > new_len) begin
                  day_in = new_len;
               end
               state_in = ctk_pkg::ST_FINISH;
            end
         end
         ctk_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ctk_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ctk_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ctk_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
         hour_ff      <= '0;
         day_ff       <= 5'd1;
         month_ff     <= '0;
         year_ff      <= '0;
         days_ff      <= '0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         hour_ff      <= hour_in;
         day_ff       <= day_in;
         month_ff     <= month_in;
         year_ff      <= year_in;
         days_ff      <= days_in;
      end
      op_ff       <= op_in;
      walk_day_ff <= walk_day_in;
      t_lo_ff     <= t_lo_in;
      if (rsp_load) begin
         rsp_hour_ff  <= hour_ff;
         rsp_day_ff   <= day_ff;
         rsp_month_ff <= month_ff;
         rsp_year_ff  <= year_ff;
         rsp_days_ff  <= days_ff;
         rsp_flag_ff  <= flag;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_hour_of_day  = rsp_hour_ff;
   assign rsp_day_of_month = rsp_day_ff;
   assign rsp_month_index  = rsp_month_ff;
   assign rsp_year_count   = rsp_year_ff;
   assign rsp_days_elapsed = rsp_days_ff;
   assign rsp_date_changed = rsp_flag_ff;

`ifndef SYNTHESIS
   a_hour_in_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_hour_ff < ctk_pkg::HOUR_LIMIT)
      else $error("hour of day not below 24 hours");

   a_day_fits_month: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> (rsp_day_ff != 5'd0 && rsp_month_ff <= ctk_pkg::LAST_MONTH
                        && rsp_day_ff <= ctk_pkg::month_len(rsp_month_ff)))
      else $error("result date out of range");

   a_walk_sane: assert property (@(posedge clock) disable iff (reset)
      state_ff == ctk_pkg::ST_WALK |-> (walk_day_ff != 9'd0
                                        && month_ff <= ctk_pkg::LAST_MONTH))
      else $error("month walk out of range");

   a_done_when_waiting: assert property (@(posedge clock) disable iff (reset)
      div_rsp.done |-> (state_ff == ctk_pkg::ST_DIV_HOUR || state_ff == ctk_pkg::ST_DIV_DAY
                        || state_ff == ctk_pkg::ST_DIV_MONTH))
      else $error("divider finished outside a divide state");
`endif

endmodule

`default_nettype wire

@@ sv/ctk_divider.sv @@
`default_nettype none

// Constant divide on one shared multiplier: scale by the reciprocal, take the
// quotient, then multiply it back for the remainder.
module ctk_divider (
   input  wire                   clock,
   input  wire                   reset,
   input  ctk_pkg::div_req_type  div_req,
   output ctk_pkg::div_rsp_type  div_rsp
);

   localparam logic [1:0] LAST_STEP = 2'd2;

   logic                               busy_ff, busy_in;
   logic                               done_ff, done_in;
   logic [1:0]                         cnt_ff, cnt_in;
   logic [ctk_pkg::DIV_WIDTH-1:0]      x_ff, x_in;
   logic [ctk_pkg::REM_WIDTH-1:0]      divisor_ff, divisor_in;
   logic [ctk_pkg::MAGIC_WIDTH-1:0]    magic_ff, magic_in;
   logic [ctk_pkg::SCALE_WIDTH-1:0]    scale_ff, scale_in;
   logic [ctk_pkg::PROD_WIDTH-1:0]     prod_ff, prod_in;
   logic [ctk_pkg::DIV_WIDTH-1:0]      quo_ff, quo_in;
   logic [ctk_pkg::REM_WIDTH-1:0]      rem_ff, rem_in;
   logic [ctk_pkg::DIV_WIDTH-1:0]      mul_a;
   logic [ctk_pkg::MAGIC_WIDTH-1:0]    mul_b;
   logic [ctk_pkg::PROD_WIDTH-1:0]     mul_out;
   logic [ctk_pkg::PROD_WIDTH-1:0]     scaled;

   assign mul_a   = (cnt_ff == 2'd0) ? x_ff : quo_ff;
   assign mul_b   = (cnt_ff == 2'd0) ? magic_ff
                  : {{(ctk_pkg::MAGIC_WIDTH-ctk_pkg::REM_WIDTH){1'b0}}, divisor_ff};
   assign mul_out = {{ctk_pkg::MAGIC_WIDTH{1'b0}}, mul_a}
                  * {{ctk_pkg::DIV_WIDTH{1'b0}}, mul_b};
   assign scaled  = prod_ff >> scale_ff;

   always_comb begin
      busy_in    = busy_ff;
      done_in    = 1'b0;
      cnt_in     = cnt_ff;
      x_in       = x_ff;
      divisor_in = divisor_ff;
      magic_in   = magic_ff;
      scale_in   = scale_ff;
      prod_in    = prod_ff;
      quo_in     = quo_ff;
      rem_in     = rem_ff;
      if (div_req.start) begin
         busy_in    = 1'b1;
         cnt_in     = '0;
         x_in       = div_req.dividend;
         divisor_in = div_req.divisor;
         magic_in   = div_req.magic;
         scale_in   = div_req.scale;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 2'd1;
         if (cnt_ff == 2'd0) begin
            prod_in = mul_out;
         end else if (cnt_ff == 2'd1) begin
            quo_in = scaled[ctk_pkg::DIV_WIDTH-1:0];
         end else begin
            rem_in  = ctk_pkg::REM_WIDTH'(x_ff - mul_out[ctk_pkg::DIV_WIDTH-1:0]);
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      x_ff       <= x_in;
      divisor_ff <= divisor_in;
      magic_ff   <= magic_in;
      scale_ff   <= scale_in;
      prod_ff    <= prod_in;
      quo_ff     <= quo_in;
      rem_ff     <= rem_in;
   end

   assign div_rsp.done      = done_ff;
   assign div_rsp.quotient  = quo_ff;
   assign div_rsp.remainder = rem_ff;

`ifndef SYNTHESIS
   a_no_restart: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !busy_ff)
      else $error("divider restarted while busy");

   a_rem_below_divisor: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> rem_ff < divisor_ff)
      else $error("remainder not below divisor");

   a_busy_from_start: assert property (@(posedge clock) disable iff (reset)
      $rose(busy_ff) |-> $past(div_req.start))
      else $error("divider went busy without start");

   a_step_bound: assert property (@(posedge clock) disable iff (reset)
      busy_ff |-> cnt_ff <= LAST_STEP)
      else $error("divider step count out of range");
`endif

endmodule

`default_nettype wire
